### rtl/hep_pkg.sv
package hep_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned HASH_W   = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
  localparam logic [HASH_W-1:0] SEED_KEY  = 32'h0000_1337;

  // code 3 is unused and ignored
  typedef enum logic [ACTION_W-1:0] {
    ACT_SEED    = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_REQUEST = 2'd2
  } action_e;

endpackage

### rtl/hep_pool_mem.sv
module hep_pool_mem
  import hep_pkg::*;
#(
  parameter int unsigned POOL_BYTES = 32,
  localparam int unsigned IDX_W = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0]     mem_q [POOL_BYTES];
  logic [POOL_BYTES-1:0] valid_q;
  logic [BYTE_W-1:0]     rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

### rtl/hep_ctrl.sv
module hep_ctrl
  import hep_pkg::*;
#(
  parameter int unsigned POOL_BYTES = 32,
  localparam int unsigned IDX_W = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] in_action_i,
  input  logic [BYTE_W-1:0]   in_seed_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BYTE_W-1:0]   out_byte_o,
  output logic                mem_re_o,
  output logic [IDX_W-1:0]    mem_raddr_o,
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output logic [BYTE_W-1:0]   mem_wdata_o,
  input  logic [BYTE_W-1:0]   mem_rdata_i
);

  localparam int unsigned POS_W = $clog2(POOL_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_BYTES - 1);
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(POOL_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_WB,
    ST_MIX_MUL,
    ST_MIX_WB,
    ST_REQ_DATA,
    ST_REQ_HOLD
  } state_e;

  state_e              state_q;
  logic [POS_W-1:0]    read_pos_q;
  logic [IDX_W-1:0]    seed_pos_q;
  logic [HASH_W-1:0]   counter_q;
  logic [IDX_W-1:0]    k_q;
  logic [HASH_W-1:0]   h_q;
  logic [HASH_W-1:0]   prod_q;
  logic [BYTE_W-1:0]   byte_q;
  logic                mix_req_q;
  logic                out_valid_q;
  logic [BYTE_W-1:0]   out_byte_q;

  logic                accept;
  logic                pool_used;
  logic [HASH_W-1:0]   mix_in;
  logic                out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign pool_used   = (read_pos_q == POS_FULL);
  assign mix_in      = h_q ^ {{(HASH_W-BYTE_W){1'b0}}, mem_rdata_i};
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_action_i)
            ACT_SEED: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = seed_pos_q;
            end
            ACT_FINISH: begin
              mem_re_o = 1'b1;
            end
            ACT_REQUEST: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = pool_used ? '0 : read_pos_q[IDX_W-1:0];
            end
            default: ;
          endcase
        end
      end
      ST_SEED_WB: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = seed_pos_q;
        mem_wdata_o = mem_rdata_i ^ byte_q;
      end
      ST_MIX_WB: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = k_q;
        mem_wdata_o = prod_q[BYTE_W-1:0];
        // fetch the next byte, or byte zero for the request that triggered the remix
        if (k_q != LAST_IDX) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = k_q + 1'b1;
        end else if (mix_req_q) begin
          mem_re_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      read_pos_q  <= '0;
      seed_pos_q  <= '0;
      counter_q   <= '0;
      k_q         <= '0;
      h_q         <= '0;
      prod_q      <= '0;
      byte_q      <= '0;
      mix_req_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (in_action_i)
              ACT_SEED: begin
                byte_q  <= in_seed_i;
                state_q <= ST_SEED_WB;
              end
              ACT_FINISH: begin
                h_q       <= FNV_BASIS ^ SEED_KEY;
                k_q       <= '0;
                mix_req_q <= 1'b0;
                state_q   <= ST_MIX_MUL;
              end
              ACT_REQUEST: begin
                if (pool_used) begin
                  h_q       <= FNV_BASIS ^ counter_q;
                  k_q       <= '0;
                  mix_req_q <= 1'b1;
                  state_q   <= ST_MIX_MUL;
                end else begin
                  read_pos_q <= read_pos_q + 1'b1;
                  state_q    <= ST_REQ_DATA;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEED_WB: begin
          seed_pos_q <= (seed_pos_q == LAST_IDX) ? '0 : seed_pos_q + 1'b1;
          state_q    <= ST_IDLE;
        end
        ST_MIX_MUL: begin
          prod_q  <= mix_in * FNV_PRIME;
          state_q <= ST_MIX_WB;
        end
        ST_MIX_WB: begin
          h_q <= prod_q >> 3;
          if (k_q != LAST_IDX) begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_MIX_MUL;
          end else if (mix_req_q) begin
            counter_q  <= counter_q + 1'b1;
            read_pos_q <= POS_W'(1);
            state_q    <= ST_REQ_DATA;
          end else begin
            seed_pos_q <= '0;
            read_pos_q <= '0;
            state_q    <= ST_IDLE;
          end
        end
        ST_REQ_DATA: begin
          if (out_free) begin
            out_byte_q  <= mem_rdata_i;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else begin
            byte_q  <= mem_rdata_i;
            state_q <= ST_REQ_HOLD;
          end
        end
        ST_REQ_HOLD: begin
          if (out_ready_i) begin
            out_byte_q  <= byte_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/hashed_entropy_pool_top.sv
// Hashed entropy pool.
// Input stream: tuser carries the action (seed one byte, finish seeding and
// mix, request one byte), tdata the seed byte. Output stream: one word with
// the next random byte per request; seed and finish give no word.
// A seed word reads its pool byte, then XORs the seed in and writes it back
// into the pool RAM. A request reads the RAM, then the output register loads.
// Finish seeding runs one hash pass, a RAM read / 32x32 constant multiply /
// write-back loop over every pool byte. A request that finds the pool used
// up runs the same pass with the remix counter first.
// One word is worked on at a time; s_axis_tready_o is high when the
// sequencer is idle. The output register lets the next word be taken while a
// result still waits. If the receiver stalls, a second result parks in a hold
// register and the sequencer waits there until the output frees up.
// Reset (rst_ni, asynchronous, active low) clears positions, the remix
// counter and the per-entry valid bits, so the pool reads as all zero right
// away; no clearing pass is needed.
module hashed_entropy_pool_top
  import hep_pkg::*;
#(
  parameter int unsigned POOL_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [BYTE_W-1:0]   s_axis_tdata_i,   // [7:0] seed_byte
  input  logic [ACTION_W-1:0] s_axis_tuser_i,   // [1:0] action
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [BYTE_W-1:0]   m_axis_tdata_o    // [7:0] random_byte
);

  localparam int unsigned IDX_W = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;

  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  // sequencer: positions, remix counter, hash pass, output register
  hep_ctrl #(
    .POOL_BYTES(POOL_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_action_i(s_axis_tuser_i),
    .in_seed_i  (s_axis_tdata_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_byte_o (m_axis_tdata_o),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  // pool RAM, one read and one write port, registered read
  hep_pool_mem #(
    .POOL_BYTES(POOL_BYTES)
  ) u_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule
